@@ design/osrft_pkg.sv @@
// ----------------------------------------------------------------------------
// osrft_pkg: shared types and constants of the one-shot redirect flow table
// Table geometry, command codes and the per-entry record.
// ----------------------------------------------------------------------------
`default_nettype none
package osrft_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int TIMEOUT_W = 20;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [15:0] dest_port;
      logic [15:0] source_port;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [15:0] router;
      logic [31:0] expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // compare request from the sequencer to the shared unit
   typedef struct packed {
      key_type     key;
      logic [31:0] now;
      logic [31:0] best_expiry;
   } cmp_req_type;

   typedef struct packed {
      logic key_match;
      logic earlier;    // entry expiry before best expiry
      logic expired;    // now at or past entry expiry
   } cmp_rsp_type;

endpackage
`default_nettype wire

@@ design/osrft_ram.sv @@
// ----------------------------------------------------------------------------
// osrft_ram: generic simple dual-port RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module osrft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH>1?DEPTH:2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH>1?DEPTH:2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/osrft_cmp.sv @@
// ----------------------------------------------------------------------------
// osrft_cmp: shared compare unit
// Key equality and wrap-aware time compares against one stored entry.
// ----------------------------------------------------------------------------
`default_nettype none
module osrft_cmp
   import osrft_pkg::*;
(
   input  wire entry_type   entry,
   input  wire cmp_req_type req,
   output cmp_rsp_type      rsp
);
   logic [31:0] diff_best;
   logic [31:0] diff_now;

   assign diff_best = entry.expiry - req.best_expiry;
   assign diff_now  = req.now - entry.expiry;

   assign rsp.key_match = (entry.key == req.key);
   assign rsp.earlier   = diff_best[31];
   assign rsp.expired   = !diff_now[31];
endmodule
`default_nettype wire

@@ design/one_shot_redirect_flow_table_core.sv @@
// ----------------------------------------------------------------------------
// one_shot_redirect_flow_table_core: redirect entry table with sequencer
// ----------------------------------------------------------------------------
// Each insert, lookup or tick scans the table one entry per cycle through a single
// shared compare unit fed from a registered-read RAM; an insert then writes the
// chosen entry in a separate write state. A lookup stops at the first match.
// A no-op command skips the scan. The result is held in an output register; a
// new word is accepted only once the previous result has been taken. Valid
// bits live in flip-flops, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module one_shot_redirect_flow_table_core
   import osrft_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [15:0]          req_udp_checksum,
   input  wire logic [63:0]          req_dest_addr_high,
   input  wire logic [63:0]          req_dest_addr_low,
   input  wire logic [15:0]          req_dest_port,
   input  wire logic [15:0]          req_source_port,
   input  wire logic [15:0]          req_router_locator,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_hit,
   output logic [15:0]               rsp_caching_router_out,
   output logic [2:0]                rsp_slot_used,
   output logic                      rsp_evicted,
   output logic [3:0]                rsp_expired_count,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [TIMEOUT_W-1:0] csr_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_WRITE, ST_DONE
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   entry_type          word_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [31:0]        now_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [IDX_W:0]     rd_cnt_ff;   // address being issued
   logic [IDX_W:0]     chk_cnt_ff;  // index whose data is on rd_data
   logic               chk_live_ff;
   logic               have_free_ff;
   logic [IDX_W-1:0]   pick_ff;
   logic [31:0]        best_ff;
   logic [CNT_W-1:0]   exp_cnt_ff;

   entry_type   rd_data;
   entry_type   wr_data;
   logic        wr_en;
   logic [IDX_W-1:0] rd_addr;
   cmp_req_type creq;
   cmp_rsp_type crsp;
   logic [IDX_W-1:0] chk_idx;
   logic        chk_valid;

   assign rd_addr   = rd_cnt_ff[IDX_W-1:0];
   assign chk_idx   = chk_cnt_ff[IDX_W-1:0];
   assign chk_valid = valid_ff[chk_idx];
   assign wr_en     = (state_ff == ST_WRITE);
   assign wr_data   = {word_ff.key, word_ff.router, now_ff + 32'(timeout_ff)};

   osrft_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pick_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign creq.key         = word_ff.key;
   assign creq.now         = now_ff;
   assign creq.best_expiry = best_ff;

   osrft_cmp u_cmp (.entry(rd_data), .req(creq), .rsp(crsp));

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         now_ff      <= '0;
         timeout_ff  <= TIMEOUT_RESET;
         rsp_valid   <= 1'b0;
         chk_live_ff <= 1'b0;
      end else begin
         if (csr_valid) timeout_ff <= csr_data;
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff <= cmd_type'(req_cmd);
                  word_ff.key <= '{req_udp_checksum, req_dest_addr_high,
                                   req_dest_addr_low, req_dest_port,
                                   req_source_port};
                  word_ff.router <= req_router_locator;
                  rsp_hit                <= 1'b0;
                  rsp_caching_router_out <= '0;
                  rsp_slot_used          <= '0;
                  rsp_evicted            <= 1'b0;
                  rsp_expired_count      <= '0;
                  rd_cnt_ff    <= '0;
                  chk_live_ff  <= 1'b0;
                  have_free_ff <= 1'b0;
                  pick_ff      <= '0;
                  exp_cnt_ff   <= '0;
                  if (cmd_type'(req_cmd) == CMD_TICK) now_ff <= now_ff + 32'd1;
                  if (cmd_type'(req_cmd) == CMD_NONE) state_ff <= ST_DONE;
                  else state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_cnt_ff < (IDX_W+1)'(TABLE_ENTRIES)) begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
               end
               chk_cnt_ff  <= rd_cnt_ff;
               chk_live_ff <= (rd_cnt_ff < (IDX_W+1)'(TABLE_ENTRIES));
               if (chk_live_ff) begin
                  unique case (cmd_ff)
                     CMD_INSERT: begin
                        if (!have_free_ff) begin
                           if (!chk_valid) begin
                              have_free_ff <= 1'b1;
                              pick_ff      <= chk_idx;
                           end else if (chk_idx == '0 || crsp.earlier) begin
                              pick_ff <= chk_idx;
                              best_ff <= rd_data.expiry;
                           end
                        end
                     end
                     CMD_LOOKUP: begin
                        if (chk_valid && crsp.key_match) begin
                           valid_ff[chk_idx]      <= 1'b0;
                           rsp_hit                <= 1'b1;
                           rsp_caching_router_out <= rd_data.router;
                           rsp_slot_used          <= 3'(chk_idx);
                           state_ff               <= ST_DONE;
                        end
                     end
                     CMD_TICK: begin
                        if (chk_valid && crsp.expired) begin
                           valid_ff[chk_idx] <= 1'b0;
                           exp_cnt_ff        <= exp_cnt_ff + 1'b1;
                        end
                     end
                     default: ;
                  endcase
                  if (chk_cnt_ff == (IDX_W+1)'(TABLE_ENTRIES - 1)
                      && !(cmd_ff == CMD_LOOKUP && chk_valid && crsp.key_match))
                  begin
                     state_ff <= (cmd_ff == CMD_INSERT) ? ST_WRITE : ST_DONE;
                  end
               end
            end
            ST_WRITE: begin
               valid_ff[pick_ff] <= 1'b1;
               rsp_slot_used     <= 3'(pick_ff);
               rsp_evicted       <= !have_free_ff;
               state_ff          <= ST_DONE;
            end
            ST_DONE: begin
               if (cmd_ff == CMD_TICK) rsp_expired_count <= 4'(exp_cnt_ff);
               rsp_valid <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_hit_only_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> cmd_ff == CMD_LOOKUP)
      else $error("hit on non-lookup");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("ready while busy");
   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |=> valid_ff[$past(pick_ff)])
      else $error("insert did not set valid");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_used))
      else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ bench/one_shot_redirect_flow_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// one_shot_redirect_flow_table_core_tb: self-checking bench for the flow table
// Drives insert, lookup and tick words with random bursts and response stalls,
// predicts every result from a behavioural copy of the table and checks each
// response field by field. The timeout register is rewritten between phases.
// ----------------------------------------------------------------------------
module one_shot_redirect_flow_table_core_tb;
   import osrft_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [15:0] router;
      logic [2:0]  slot;
      logic        evicted;
      logic [3:0]  expired;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  cmd;
      key_type     key;
      logic [15:0] router;
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic [15:0] req_udp_checksum = '0;
   logic [63:0] req_dest_addr_high = '0;
   logic [63:0] req_dest_addr_low = '0;
   logic [15:0] req_dest_port = '0;
   logic [15:0] req_source_port = '0;
   logic [15:0] req_router_locator = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [15:0] rsp_caching_router_out;
   logic [2:0] rsp_slot_used;
   logic rsp_evicted;
   logic [3:0] rsp_expired_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TIMEOUT_W-1:0] csr_data = '0;

   one_shot_redirect_flow_table_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_udp_checksum(req_udp_checksum), .req_dest_addr_high(req_dest_addr_high),
      .req_dest_addr_low(req_dest_addr_low), .req_dest_port(req_dest_port),
      .req_source_port(req_source_port), .req_router_locator(req_router_locator),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_caching_router_out(rsp_caching_router_out), .rsp_slot_used(rsp_slot_used),
      .rsp_evicted(rsp_evicted), .rsp_expired_count(rsp_expired_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // behavioural copy of the table
   logic        flow_valid [TABLE_ENTRIES] = '{default: 1'b0};
   key_type     flow_key [TABLE_ENTRIES];
   logic [15:0] flow_router [TABLE_ENTRIES];
   logic [31:0] flow_expiry [TABLE_ENTRIES];
   logic [31:0] clock_ms = '0;
   logic [TIMEOUT_W-1:0] lifetime_ms = TIMEOUT_RESET;

   rsp_word_type pending_rsp [$];
   int mismatches = 0;
   int rsp_seen = 0;
   int words_sent = 0;
   int hits_seen = 0;
   int evictions_seen = 0;
   int expiries_seen = 0;
   int stall_mode = 0;

   // key pool, so lookups actually hit inserted flows
   key_type key_pool [16];

   function automatic logic earlier_than(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic rsp_word_type table_apply(req_word_type w);
      rsp_word_type r;
      int pick;
      r = '0;
      case (cmd_type'(w.cmd))
         CMD_INSERT: begin
            pick = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (pick < 0 && !flow_valid[i]) pick = i;
            if (pick < 0) begin
               pick = 0;
               for (int i = 1; i < TABLE_ENTRIES; i++)
                  if (earlier_than(flow_expiry[i], flow_expiry[pick])) pick = i;
               r.evicted = 1'b1;
            end
            flow_valid[pick] = 1'b1;
            flow_key[pick] = w.key;
            flow_router[pick] = w.router;
            flow_expiry[pick] = clock_ms + 32'(lifetime_ms);
            r.slot = 3'(pick);
         end
         CMD_LOOKUP: begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (!r.hit && flow_valid[i] && flow_key[i] == w.key) begin
                  r.hit = 1'b1;
                  r.router = flow_router[i];
                  r.slot = 3'(i);
                  flow_valid[i] = 1'b0;
               end
         end
         CMD_TICK: begin
            clock_ms = clock_ms + 32'd1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (flow_valid[i] && !earlier_than(clock_ms, flow_expiry[i])) begin
                  flow_valid[i] = 1'b0;
                  if (r.expired < 4'd15) r.expired = r.expired + 4'd1;
               end
         end
         default: ;
      endcase
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_hit, rsp_caching_router_out, rsp_slot_used, rsp_evicted,
                rsp_expired_count};
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: hit %b/%b router %h/%h slot %0d/%0d evict %b/%b exp %0d/%0d",
                           want.hit, got.hit, want.router, got.router, want.slot, got.slot,
                           want.evicted, got.evicted, want.expired, got.expired);
            end
            if (got.hit) hits_seen++;
            if (got.evicted) evictions_seen++;
            if (got.expired != 0) expiries_seen++;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      int cnt;
      cnt++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ((cnt % 7) < 3);
      endcase
   end

   int gap_left = 0;

   // returns at the accepting edge; valid stays up until the next word or a drain
   task automatic send_word(req_word_type w);
      @(negedge clock);
      if (gap_left > 0) begin
         req_valid <= 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end else if ($urandom_range(0, 5) == 0) begin
         gap_left = $urandom_range(1, 12);
      end
      req_cmd <= w.cmd;
      req_udp_checksum <= w.key.checksum;
      req_dest_addr_high <= w.key.addr_high;
      req_dest_addr_low <= w.key.addr_low;
      req_dest_port <= w.key.dest_port;
      req_source_port <= w.key.source_port;
      req_router_locator <= w.router;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(table_apply(w));
      words_sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_lifetime(logic [TIMEOUT_W-1:0] v);
      drain();
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      lifetime_ms = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic key_type random_key();
      key_type k;
      k.checksum = 16'($urandom);
      k.addr_high = {$urandom, $urandom};
      k.addr_low = {$urandom, $urandom};
      k.dest_port = 16'($urandom);
      k.source_port = 16'($urandom);
      return k;
   endfunction

   function automatic req_word_type make_word(cmd_type c, key_type k, logic [15:0] r);
      req_word_type w;
      w.cmd = c;
      w.key = k;
      w.router = r;
      return w;
   endfunction

   task automatic test_directed;
      key_type ones, zeros;
      ones = '1;
      zeros = '0;
      send_word(make_word(CMD_LOOKUP, zeros, 16'h0));          // miss on empty table
      send_word(make_word(CMD_INSERT, zeros, 16'hffff));
      send_word(make_word(CMD_INSERT, ones, 16'h0001));
      send_word(make_word(CMD_INSERT, ones, 16'h0002));        // duplicate key
      send_word(make_word(CMD_LOOKUP, ones, 16'h0));           // lowest index wins
      send_word(make_word(CMD_LOOKUP, ones, 16'h0));
      send_word(make_word(CMD_LOOKUP, ones, 16'h0));           // consumed, now a miss
      send_word(make_word(CMD_NONE, ones, 16'hffff));          // unused command
      send_word(make_word(CMD_LOOKUP, zeros, 16'h0));
      for (int i = 0; i < 10; i++)                             // fill and evict
         send_word(make_word(CMD_INSERT, key_pool[i], 16'(i + 16'h100)));
      send_word(make_word(CMD_TICK, zeros, 16'h0));
   endtask

   task automatic test_zero_lifetime;
      write_lifetime('0);
      send_word(make_word(CMD_INSERT, key_pool[3], 16'h1234));
      send_word(make_word(CMD_TICK, key_pool[3], 16'h0));
      send_word(make_word(CMD_LOOKUP, key_pool[3], 16'h0));
      for (int i = 0; i < 9; i++)
         send_word(make_word(CMD_INSERT, key_pool[i], 16'(i)));
      send_word(make_word(CMD_TICK, key_pool[0], 16'h0));      // mass expiry
   endtask

   task automatic test_random(int n, int tick_weight);
      req_word_type w;
      int roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) w = make_word(cmd_type'($urandom_range(0, 3)), random_key(),
                                     16'($urandom));
         else if (roll < 5 + tick_weight)
            w = make_word(CMD_TICK, key_pool[$urandom_range(0, 15)], 16'($urandom));
         else if (roll < 55 + tick_weight / 2)
            w = make_word(CMD_INSERT, key_pool[$urandom_range(0, 15)], 16'($urandom));
         else
            w = make_word(CMD_LOOKUP, key_pool[$urandom_range(0, 15)], 16'($urandom));
         send_word(w);
         if ($urandom_range(0, 40) == 0) stall_mode = $urandom_range(0, 2);
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) key_pool[i] = random_key();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_zero_lifetime();
      write_lifetime(20'd1);
      stall_mode = 1;
      test_random(350, 30);
      write_lifetime(20'd1000000);
      stall_mode = 2;
      test_random(350, 10);
      write_lifetime(20'd6);
      test_random(350, 40);
      write_lifetime(20'($urandom_range(1, 40)));
      test_random(350, 25);
      drain();
      repeat (20) @(negedge clock);
      $display("%0d words sent, %0d responses checked", words_sent, rsp_seen);
      $display("%0d hits, %0d evictions, %0d ticks with expiries",
               hits_seen, evictions_seen, expiries_seen);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ one_shot_redirect_flow_table_core.f @@
design/osrft_pkg.sv
design/osrft_ram.sv
design/osrft_cmp.sv
design/one_shot_redirect_flow_table_core.sv
bench/one_shot_redirect_flow_table_core_tb.sv
